### rtl/tpfm_pkg.sv
// shared types, constants and sine table function for the two-phase foc modulator
package tpfm_pkg;

  // default quarter-wave table resolution
  localparam int unsigned SINE_TABLE_BITS_DEF = 8;

  // configuration port widths and register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULATION_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_LIMIT    = 1'd1;

  // reset value of the supply limit register
  localparam logic [14:0] SUPPLY_LIMIT_RST = 15'd3072;

  // fixed-point constants for the table build
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] HALF_Q30    = 64'd536870912;
  localparam logic [63:0] SINE_MAX    = 64'd32767;

  // modulation modes
  typedef enum logic [1:0] {
    MODE_SINE    = 2'd0,
    MODE_SVPWM   = 2'd1,
    MODE_TRAP120 = 2'd2,
    MODE_TRAP150 = 2'd3
  } mode_e;

  // input transaction payload
  typedef struct packed {
    logic signed [15:0] volt_q;
    logic signed [15:0] volt_d;
    logic        [15:0] elec_angle;
  } in_t;

  // output transaction payload
  typedef struct packed {
    logic signed [15:0] coil_a_volt;
    logic signed [15:0] coil_b_volt;
    logic signed [15:0] mid_leg_volt;
  } out_t;

  // one quarter-wave entry, unsigned q0.15: taylor series in q2.30, evaluated at elaboration
  function automatic logic [14:0] sine_entry(input int unsigned idx, input int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    longint      sum;
    x    = (HALF_PI_Q30 * 64'(idx)) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = (term * x2) >> 30;
      case (k)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if ((k % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (64'(sum) * SINE_MAX + HALF_Q30) >> 30;
    if (v > SINE_MAX) begin
      v = SINE_MAX;
    end
    return v[14:0];
  endfunction

endpackage

### rtl/two_phase_foc_modulator_unit.sv
// top level: inverse park rotation and sine / space-vector bias for a shared-leg stepper
//
//   channel   direction  handshake                payload
//   in        input      in_valid_i / in_stall_o  in_data_i  (volt_q, volt_d, elec_angle)
//   out       output     out_valid_o / out_stall_i out_data_o (coil_a, coil_b, mid_leg)
//   cfg       input      cfg_we_i                 cfg_index_i, cfg_data_i
//
// one transaction per cycle sustained while out_stall_i is low, through six register stages
// (table read, interpolation, products, rounding, bias, saturation).
// reset clears the stage valid bits and the two registers; there is no clearing pass.
// a stage holds its item only while full and the stage after it is blocked, so bubbles are
// squeezed out; while a stage is empty, input is taken even as a result waits at the output.
module two_phase_foc_modulator_unit #(
  parameter int unsigned SINE_TABLE_BITS = tpfm_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  tpfm_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output tpfm_pkg::out_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [tpfm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tpfm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned FRAC_BITS = 14 - SINE_TABLE_BITS;
  localparam int unsigned PROD_W    = 15 + FRAC_BITS;
  localparam int unsigned NSTAGE    = 6;

  // saturate to signed q8.8
  function automatic logic [15:0] sat16(input logic signed [20:0] v);
    logic [15:0] r;
    if (v > 21'sd32767) begin
      r = 16'h7FFF;
    end else if (v < -21'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // configuration registers
  tpfm_pkg::mode_e mode_q;
  logic [14:0]     supply_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= tpfm_pkg::MODE_SINE;
      supply_q <= tpfm_pkg::SUPPLY_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tpfm_pkg::CFG_MODULATION_MODE: mode_q   <= tpfm_pkg::mode_e'(cfg_data_i[1:0]);
        tpfm_pkg::CFG_SUPPLY_LIMIT:    supply_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage advance
  logic [NSTAGE-1:0] v_q;
  logic [NSTAGE-1:0] v_d;
  logic [NSTAGE-1:0] rdy;

  always_comb begin
    rdy[NSTAGE-1] = !v_q[NSTAGE-1] || !out_stall_i;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    v_d[0] = rdy[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NSTAGE; k++) begin
      v_d[k] = rdy[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = v_q[NSTAGE-1];

  // stage 0: table lookup for sine and cosine
  logic [14:0]          sin_lo, sin_hi, cos_lo, cos_hi;
  logic [FRAC_BITS-1:0] sin_frac, cos_frac;
  logic                 sin_neg, cos_neg;
  logic [15:0]          cos_angle;

  assign cos_angle = in_data_i.elec_angle + 16'd16384;

  tpfm_sin_lut #(.TABLE_BITS(SINE_TABLE_BITS)) u_sin_lut (
    .angle_i (in_data_i.elec_angle),
    .lo_o    (sin_lo),
    .hi_o    (sin_hi),
    .frac_o  (sin_frac),
    .neg_o   (sin_neg)
  );

  tpfm_sin_lut #(.TABLE_BITS(SINE_TABLE_BITS)) u_cos_lut (
    .angle_i (cos_angle),
    .lo_o    (cos_lo),
    .hi_o    (cos_hi),
    .frac_o  (cos_frac),
    .neg_o   (cos_neg)
  );

  logic [14:0]          sin_lo_q, sin_hi_q, cos_lo_q, cos_hi_q;
  logic [FRAC_BITS-1:0] sin_frac_q, cos_frac_q;
  logic                 sin_neg_q, cos_neg_q;
  logic signed [15:0]   vq0_q, vd0_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      sin_lo_q   <= sin_lo;
      sin_hi_q   <= sin_hi;
      sin_frac_q <= sin_frac;
      sin_neg_q  <= sin_neg;
      cos_lo_q   <= cos_lo;
      cos_hi_q   <= cos_hi;
      cos_frac_q <= cos_frac;
      cos_neg_q  <= cos_neg;
      vq0_q      <= in_data_i.volt_q;
      vd0_q      <= in_data_i.volt_d;
    end
  end

  // stage 1: linear interpolation, floor, then quadrant sign
  logic [PROD_W-1:0]  sin_prod, cos_prod;
  logic [15:0]        sin_mag, cos_mag;
  logic signed [15:0] sa_d, ca_d;
  logic signed [15:0] sa_q, ca_q, vq1_q, vd1_q;

  always_comb begin
    sin_prod = PROD_W'(sin_hi_q - sin_lo_q) * PROD_W'(sin_frac_q);
    cos_prod = PROD_W'(cos_hi_q - cos_lo_q) * PROD_W'(cos_frac_q);
    sin_mag  = {1'b0, sin_lo_q} + {1'b0, sin_prod[PROD_W-1:FRAC_BITS]};
    cos_mag  = {1'b0, cos_lo_q} + {1'b0, cos_prod[PROD_W-1:FRAC_BITS]};
    sa_d     = sin_neg_q ? -$signed(sin_mag) : $signed(sin_mag);
    ca_d     = cos_neg_q ? -$signed(cos_mag) : $signed(cos_mag);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      sa_q  <= sa_d;
      ca_q  <= ca_d;
      vq1_q <= vq0_q;
      vd1_q <= vd0_q;
    end
  end

  // stage 2: rotation products, q1.15 times q8.8
  logic signed [31:0] p_cd_q, p_sq_q, p_sd_q, p_cq_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      p_cd_q <= ca_q * vd1_q;
      p_sq_q <= sa_q * vq1_q;
      p_sd_q <= sa_q * vd1_q;
      p_cq_q <= ca_q * vq1_q;
    end
  end

  // stage 3: exact sums, round to q8.8 with floor shift
  logic signed [32:0] sum_a, sum_b, rnd_a, rnd_b;
  logic signed [17:0] a_q, b_q;

  always_comb begin
    sum_a = 33'(p_cd_q) - 33'(p_sq_q);
    sum_b = 33'(p_sd_q) + 33'(p_cq_q);
    rnd_a = sum_a + 33'sd16384;
    rnd_b = sum_b + 33'sd16384;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      a_q <= rnd_a[32:15];
      b_q <= rnd_b[32:15];
    end
  end

  // stage 4: bias, half supply or space-vector midpoint shift
  logic signed [17:0] mn, mx;
  logic signed [19:0] sv_sum, off_d;
  logic signed [19:0] off_q;
  logic signed [17:0] a4_q, b4_q;

  always_comb begin
    mn     = (a_q < b_q) ? a_q : b_q;
    mx     = (a_q > b_q) ? a_q : b_q;
    if (mn > 18'sd0) begin
      mn = 18'sd0;
    end
    if (mx < 18'sd0) begin
      mx = 18'sd0;
    end
    sv_sum = $signed({5'd0, supply_q}) - 20'(mn) - 20'(mx);
    if (mode_q == tpfm_pkg::MODE_SINE) begin
      off_d = $signed({6'd0, supply_q[14:1]});
    end else begin
      off_d = {sv_sum[19], sv_sum[19:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      off_q <= off_d;
      a4_q  <= a_q;
      b4_q  <= b_q;
    end
  end

  // stage 5: add bias and saturate; trapezoid modes drive zero
  tpfm_pkg::out_t out_d, out_q;
  logic           trap_mode;

  assign trap_mode = (mode_q == tpfm_pkg::MODE_TRAP120) || (mode_q == tpfm_pkg::MODE_TRAP150);

  always_comb begin
    if (trap_mode) begin
      out_d = '0;
    end else begin
      out_d.coil_a_volt  = sat16(21'(a4_q) + 21'(off_q));
      out_d.coil_b_volt  = sat16(21'(b4_q) + 21'(off_q));
      out_d.mid_leg_volt = sat16(21'(off_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // an accepted transaction lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v_q[0])
    else $error("accepted input did not enter stage 0");

  // a full stage that cannot advance keeps its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (($past(v_q & ~rdy) & ~v_q) == '0))
    else $error("stalled stage lost its item");

  // an empty output stage never stalls the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NSTAGE-1] |-> !in_stall_o)
    else $error("input stalled with empty output stage");

  // a stage with no item in front of it and able to advance becomes empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[0] && rdy[1] && v_q[1] |=> !v_q[1])
    else $error("pipeline bubble tracking broken");

endmodule

### rtl/tpfm_sin_lut.sv
// quarter-wave sine table lookup: quadrant fold, table read of both neighbors
module tpfm_sin_lut #(
  parameter int unsigned TABLE_BITS = tpfm_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic [15:0]            angle_i,
  output logic [14:0]            lo_o,
  output logic [14:0]            hi_o,
  output logic [13-TABLE_BITS:0] frac_o,
  output logic                   neg_o
);

  localparam int unsigned FRAC_BITS = 14 - TABLE_BITS;
  localparam int unsigned TABLE_LEN = (1 << TABLE_BITS) + 1;
  localparam int unsigned IDX_W     = TABLE_BITS + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(1 << TABLE_BITS);

  logic [14:0]      tab [TABLE_LEN];
  logic [1:0]       quad;
  logic [14:0]      pos;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_hi;

  // constant table
  for (genvar i = 0; i < TABLE_LEN; i++) begin : g_tab
    assign tab[i] = tpfm_pkg::sine_entry(i, TABLE_BITS);
  end

  // fold angle into the first quadrant
  assign quad = angle_i[15:14];
  assign pos  = quad[0] ? (15'd16384 - {1'b0, angle_i[13:0]}) : {1'b0, angle_i[13:0]};
  assign idx  = pos[14:FRAC_BITS];

  // upper neighbor clamps at the quarter point, where frac is zero
  assign idx_hi = (idx == LAST_IDX) ? idx : idx + IDX_W'(1);

  assign lo_o   = tab[idx];
  assign hi_o   = tab[idx_hi];
  assign frac_o = pos[FRAC_BITS-1:0];
  assign neg_o  = quad[1];

endmodule
